// ===== design/sfp_pkg.sv =====
// sfp_pkg: item types, status codes and identifier length decode for the
// sensor frame field parser. No dependencies.
package sfp_pkg;

    localparam int unsigned LenW = 5;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_UNKNOWN = 2'd1,
        ST_TRUNC   = 2'd2,
        ST_RSVD    = 2'd3
    } t_status;

    localparam logic [7:0] CODE_QUAT = 8'd77;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_end;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  field_code;
        logic [31:0] field_value;
        logic [1:0]  element_index;
        t_status     parse_status;
    } t_out_item;

    // payload length in bytes for an identifier, zero when unknown
    function automatic logic [LenW-1:0] payload_length(input logic [7:0] code);
        logic [LenW-1:0] len;
        case (code)
            8'd5, 8'd7, 8'd21, 8'd22, 8'd23, 8'd24, 8'd25,
            8'd27, 8'd28, 8'd29, 8'd74, 8'd75, 8'd76: len = LenW'(4);
            8'd8, 8'd9, 8'd79:                        len = LenW'(1);
            CODE_QUAT:                                len = LenW'(16);
            default:                                  len = '0;
        endcase
        return len;
    endfunction

endpackage

// ===== design/sensor_frame_field_parser_unit.sv =====
// result: registered in the result register, or in the skid stage when stalled.
// throughput: one byte per cycle while the skid stage is empty; the per-byte
// state update is a single pass of decode and shift logic, and a one-entry
// skid stage keeps input acceptance going while a result waits on the output.
// reset: synchronous, active low; clears parser state, result and skid valids.
// Sensor frame field parser top level: byte-stream TLV decode.
// Depends on sfp_pkg.
module sensor_frame_field_parser_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  sfp_pkg::t_in_item  i_in_item,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output sfp_pkg::t_out_item o_out_item
);
    import sfp_pkg::*;

    logic            r_in_payload, n_in_payload;
    logic [7:0]      r_code, n_code;
    logic [LenW-1:0] r_bytes_left, n_bytes_left;
    logic [31:0]     r_word, n_word;
    logic [1:0]      r_quat, n_quat;

    logic            r_out_valid;
    t_out_item       r_out_item;
    logic            r_skid_valid;
    t_out_item       r_skid_item;

    logic            accept;
    logic            res_valid;
    t_out_item       res;
    logic [LenW-1:0] len;
    logic [LenW-1:0] left;
    logic [31:0]     shifted;
    logic [1:0]      quat_inc;
    logic            out_free;

    assign accept   = i_in_valid && !o_in_stall;
    assign len      = payload_length(i_in_item.data_byte);
    assign left     = r_bytes_left - LenW'(1);
    assign shifted  = {r_word[23:0], i_in_item.data_byte};
    assign quat_inc = r_quat + 2'd1;

    always_comb begin
        n_in_payload = r_in_payload;
        n_code       = r_code;
        n_bytes_left = r_bytes_left;
        n_word       = r_word;
        n_quat       = r_quat;
        res_valid    = 1'b0;
        res          = '{field_code: r_code, field_value: '0,
                         element_index: '0, parse_status: ST_OK};
        if (accept) begin
            if (!r_in_payload || r_bytes_left == '0) begin
                // identifier byte
                n_in_payload = 1'b0;
                n_bytes_left = '0;
                n_word       = '0;
                n_quat       = '0;
                if (len == '0) begin
                    res_valid        = 1'b1;
                    res.field_code   = i_in_item.data_byte;
                    res.parse_status = ST_UNKNOWN;
                end else begin
                    n_code = i_in_item.data_byte;
                    if (i_in_item.frame_end) begin
                        res_valid        = 1'b1;
                        res.field_code   = i_in_item.data_byte;
                        res.parse_status = ST_TRUNC;
                    end else begin
                        n_in_payload = 1'b1;
                        n_bytes_left = len;
                    end
                end
            end else if (left[1:0] == 2'd0) begin
                // a word is complete
                res_valid         = 1'b1;
                res.field_value   = shifted;
                res.element_index = r_quat;
                if (left == '0) begin
                    n_in_payload = 1'b0;
                    n_bytes_left = '0;
                    n_word       = '0;
                    n_quat       = '0;
                end else if (i_in_item.frame_end) begin
                    // truncation replaces the finished element's result
                    res.field_value   = '0;
                    res.element_index = quat_inc;
                    res.parse_status  = ST_TRUNC;
                    n_in_payload      = 1'b0;
                    n_bytes_left      = '0;
                    n_word            = '0;
                    n_quat            = '0;
                end else begin
                    n_word       = '0;
                    n_quat       = quat_inc;
                    n_bytes_left = left;
                end
            end else if (i_in_item.frame_end) begin
                res_valid         = 1'b1;
                res.field_value   = shifted;
                res.element_index = r_quat;
                res.parse_status  = ST_TRUNC;
                n_in_payload      = 1'b0;
                n_bytes_left      = '0;
                n_word            = '0;
                n_quat            = '0;
            end else begin
                n_word       = shifted;
                n_bytes_left = left;
            end
        end
    end

    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_payload <= 1'b0;
            r_code       <= '0;
            r_bytes_left <= '0;
            r_word       <= '0;
            r_quat       <= '0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_in_payload <= n_in_payload;
            r_code       <= n_code;
            r_bytes_left <= n_bytes_left;
            r_word       <= n_word;
            r_quat       <= n_quat;
            if (out_free) begin
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= res_valid;
                end
            end else if (res_valid) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out_item <= r_skid_item;
            end else if (res_valid) begin
                r_out_item <= res;
            end
        end else if (res_valid) begin
            r_skid_item <= res;
        end
    end

    assign o_in_stall  = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// ===== design/sfp_checker.sv =====
// sfp_checker: port-level assertions for the sensor frame field parser,
// bound to the top level. Depends on sfp_pkg.
module sfp_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input sfp_pkg::t_in_item  i_in_item,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input sfp_pkg::t_out_item o_out_item
);
    import sfp_pkg::*;

    // a stalled result item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result item changed");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.parse_status != ST_RSVD)
        else $error("reserved status code");

    a_unknown_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.parse_status == ST_UNKNOWN |->
            o_out_item.field_value == '0 && o_out_item.element_index == '0)
        else $error("unknown identifier item carries payload");

    // only quaternion fields have element numbers
    a_index_quat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.element_index != '0 |->
            o_out_item.field_code == CODE_QUAT)
        else $error("element index on a non-quaternion field");

    // single-byte fields keep the value in the low byte
    a_byte_field: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.field_code == 8'd8 || o_out_item.field_code == 8'd9
            || o_out_item.field_code == 8'd79) |->
            o_out_item.field_value[31:8] == '0)
        else $error("single-byte field value too wide");

endmodule

bind sensor_frame_field_parser_unit sfp_checker u_sfp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);

// ===== bench/tb_sensor_frame_field_parser_unit.sv =====
// testbench for sensor_frame_field_parser_unit: directed and random byte frames,
// with a cycle-free parser predictor checking every result item in order
// depends on sfp_pkg and the top level in design/
`timescale 1ns / 1ps

module tb_sensor_frame_field_parser_unit;
    import sfp_pkg::*;

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_item  i_in_item;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_item o_out_item;

    sensor_frame_field_parser_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    always #5 i_clk = ~i_clk;

    localparam logic [7:0] ShortIds [16] = '{
        8'd5, 8'd7, 8'd21, 8'd22, 8'd23, 8'd24, 8'd25, 8'd27,
        8'd28, 8'd29, 8'd74, 8'd75, 8'd76, 8'd8, 8'd9, 8'd79
    };

    t_out_item expected_fields[$];
    int        fail_count = 0;
    int        bytes_sent = 0;
    bit        in_gaps_on = 1'b1;
    bit        out_gaps_on = 1'b1;
    int        out_hold_cycles = 0;

    // parser state mirrored by the predictor
    logic        pr_in_payload = 1'b0;
    logic [7:0]  pr_code = '0;
    logic [4:0]  pr_left = '0;
    logic [31:0] pr_word = '0;
    logic [1:0]  pr_elem = '0;

    function automatic logic [4:0] field_length(input logic [7:0] id);
        case (id)
            8'd8, 8'd9, 8'd79: return 5'd1;
            8'd77:             return 5'd16;
            8'd5, 8'd7, 8'd21, 8'd22, 8'd23, 8'd24, 8'd25, 8'd27, 8'd28, 8'd29,
            8'd74, 8'd75, 8'd76: return 5'd4;
            default:           return 5'd0;
        endcase
    endfunction

    task automatic parser_idle();
        pr_in_payload = 1'b0;
        pr_left = '0;
        pr_word = '0;
        pr_elem = '0;
    endtask

    // advance the predicted parser by one byte, queue the result it gives
    task automatic track_byte(input logic [7:0] b, input logic last);
        t_out_item   res;
        logic        has_res;
        logic [4:0]  len;
        logic [31:0] done_word;
        logic [1:0]  done_elem;
        has_res = 1'b0;
        res = '0;
        if (!pr_in_payload || pr_left == 0) begin
            len = field_length(b);
            parser_idle();
            if (len == 0) begin
                res.field_code = b;
                res.parse_status = ST_UNKNOWN;
                has_res = 1'b1;
            end else begin
                pr_code = b;
                if (last) begin
                    res.field_code = b;
                    res.parse_status = ST_TRUNC;
                    has_res = 1'b1;
                end else begin
                    pr_in_payload = 1'b1;
                    pr_left = len;
                end
            end
        end else begin
            pr_word = {pr_word[23:0], b};
            pr_left = pr_left - 5'd1;
            res.field_code = pr_code;
            has_res = 1'b1;
            if (pr_left[1:0] == 2'd0) begin
                done_word = pr_word;
                done_elem = pr_elem;
                pr_word = '0;
                pr_elem = pr_elem + 2'd1;
                if (pr_left != 0 && last) begin
                    // element boundary inside a quaternion: truncation wins
                    res.element_index = pr_elem;
                    res.parse_status = ST_TRUNC;
                    parser_idle();
                end else begin
                    res.field_value = done_word;
                    res.element_index = done_elem;
                    res.parse_status = ST_OK;
                    if (pr_left == 0) parser_idle();
                end
            end else if (last) begin
                res.field_value = pr_word;
                res.element_index = pr_elem;
                res.parse_status = ST_TRUNC;
                parser_idle();
            end else begin
                has_res = 1'b0;
            end
        end
        if (has_res) expected_fields.push_back(res);
    endtask

    // offer one item, called right after a rising edge, returns after acceptance
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = in_gaps_on ? $urandom_range(0, 19) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item <= '{data_byte: b, frame_end: last};
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        track_byte(b, last);
        bytes_sent++;
    endtask

    // receiver: per result a random hold-off, plus a long hold when requested
    initial begin
        int wait_n;
        i_out_stall <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (out_hold_cycles > 0) begin
                i_out_stall <= 1'b1;
                repeat (out_hold_cycles) @(posedge i_clk);
                out_hold_cycles = 0;
            end
            wait_n = out_gaps_on ? $urandom_range(0, 19) : 0;
            if (wait_n > 0) begin
                i_out_stall <= 1'b1;
                repeat (wait_n) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_fields.size() == 0) begin
                $error("unexpected result item: code %0d value %h status %0d",
                       o_out_item.field_code, o_out_item.field_value,
                       o_out_item.parse_status);
                fail_count++;
            end else begin
                want = expected_fields.pop_front();
                if (o_out_item.field_code !== want.field_code) begin
                    $error("field_code expected %0d got %0d",
                           want.field_code, o_out_item.field_code);
                    fail_count++;
                end
                if (o_out_item.field_value !== want.field_value) begin
                    $error("field_value expected %h got %h",
                           want.field_value, o_out_item.field_value);
                    fail_count++;
                end
                if (o_out_item.element_index !== want.element_index) begin
                    $error("element_index expected %0d got %0d",
                           want.element_index, o_out_item.element_index);
                    fail_count++;
                end
                if (o_out_item.parse_status !== want.parse_status) begin
                    $error("parse_status expected %0d got %0d",
                           want.parse_status, o_out_item.parse_status);
                    fail_count++;
                end
            end
        end
    end

    task automatic test_unknown_ids();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
    endtask

    task automatic test_single_byte_fields();
        send_byte(8'd8, 1'b0);
        send_byte(8'h00, 1'b0);
        // frame ends right on the payload byte: normal completion
        send_byte(8'd79, 1'b0);
        send_byte(8'hFF, 1'b1);
    endtask

    task automatic test_word_field();
        send_byte(8'd21, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h01, 1'b1);
    endtask

    task automatic test_truncations();
        int k;
        // identifier as last byte of frame
        send_byte(8'd24, 1'b1);
        // frame ends partway through a word
        send_byte(8'd5, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h55, 1'b1);
        // frame ends exactly after the first quaternion element
        send_byte(8'd77, 1'b0);
        for (k = 0; k < 4; k++) send_byte(8'(8'h11 * (k + 1)), k == 3);
    endtask

    // one frame: mostly well-formed fields, sometimes cut short or plain noise
    task automatic send_random_frame();
        logic [7:0] frame_bytes[$];
        logic [7:0] id;
        int         n_fields, f, k, cut;
        n_fields = $urandom_range(1, 4);
        if ($urandom_range(0, 9) == 0) begin
            for (k = 0; k < n_fields * 2; k++) frame_bytes.push_back(8'($urandom_range(0, 255)));
        end else begin
            for (f = 0; f < n_fields; f++) begin
                case ($urandom_range(0, 11))
                    0: begin
                        do id = 8'($urandom_range(0, 255)); while (field_length(id) != 0);
                    end
                    1, 2, 3: id = 8'd77;
                    default: id = ShortIds[4'($urandom_range(0, 15))];
                endcase
                frame_bytes.push_back(id);
                for (k = 0; k < field_length(id); k++)
                    frame_bytes.push_back(8'($urandom_range(0, 255)));
            end
            if ($urandom_range(0, 3) == 0) begin
                cut = $urandom_range(1, frame_bytes.size());
                while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
            end
        end
        for (k = 0; k < frame_bytes.size(); k++) send_byte(frame_bytes[k], k == frame_bytes.size() - 1);
    endtask

    task automatic test_random_traffic(input int n_items, input bit in_gaps, input bit out_gaps);
        int stop_at;
        stop_at = bytes_sent + n_items;
        in_gaps_on = in_gaps;
        out_gaps_on = out_gaps;
        while (bytes_sent < stop_at) send_random_frame();
    endtask

    task automatic test_output_backpressure();
        int k;
        in_gaps_on = 1'b0;
        out_hold_cycles = 150;
        // back-to-back word fields, far more results than the block can hold
        for (k = 0; k < 12; k++) begin
            send_byte(8'd22, 1'b0);
            send_byte(8'($urandom_range(0, 255)), 1'b0);
            send_byte(8'($urandom_range(0, 255)), 1'b0);
            send_byte(8'($urandom_range(0, 255)), 1'b0);
            send_byte(8'($urandom_range(0, 255)), k == 11);
        end
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_item <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_unknown_ids();
        test_single_byte_fields();
        test_word_field();
        test_truncations();
        test_random_traffic(600, 1'b1, 1'b1);
        test_output_backpressure();
        test_random_traffic(400, 1'b0, 1'b0);
        test_random_traffic(400, 1'b1, 1'b0);
        test_random_traffic(400, 1'b0, 1'b1);

        i_in_valid <= 1'b0;
        while (expected_fields.size() != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $error("timeout with %0d results outstanding", expected_fields.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
